/* rtl/crcfr_pkg.sv */
// Package for the CRC-checked frame receiver: constants, codes and control structs.
package crcfr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int POS_W       = $clog2(MAX_PAYLOAD + 6);
    localparam int BYTE_W      = 8;
    localparam int CRC_W       = 16;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;

    localparam logic REG_HEADER_FIRST  = 1'b0;
    localparam logic REG_HEADER_SECOND = 1'b1;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_CRC     = 2'd1;
    localparam logic [1:0] ERR_TRAILER = 2'd2;
    localparam logic [1:0] ERR_LENGTH  = 2'd3;

    typedef struct packed {
        logic accept;
        logic crc_shift;
        logic clear_k;
        logic inc_k;
        logic load_err;
        logic load_item;
    } crcfr_cmd_t;

    typedef struct packed {
        logic ev_crc;
        logic ev_err;
        logic ev_good;
        logic k_last;
        logic can_load;
    } crcfr_status_t;

endpackage

/* rtl/crc_checked_frame_receiver_unit.sv */
// Framed byte receiver with CRC-16 (CCITT-FALSE) check.
//
// Input channel: rx_byte with in_valid/in_stall, one received word per accept.
// The receiver hunts for the two header bytes, takes a length (1..32), the
// payload, a little-endian CRC of the payload and a two-byte trailer.
// Output channel: out_kind/out_byte/error_code/last with out_valid/out_stall.
// A good frame yields its payload words then a six-word acknowledgment; a bad
// length, trailer or CRC yields one error word. last marks the final word
// caused by one input word.
// A payload word holds the input after its accept while the bit-serial
// CRC register shifts the byte in; header, length, CRC and trailer words do
// not hold it. An error word holds it until its load; a good frame's final
// trailer word starts emission of len+6 words, each by a payload memory read
// then an output register load, and the input is held until all are loaded.
// A stalled output holds its word; emission waits, and the input stays
// stalled until all words of that input are loaded.
// Reset clears the parser to hunting, restores the header registers to 0xAA
// and 0x55 and empties the output register. Configure only while idle.
module crc_checked_frame_receiver_unit
    import crcfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        out_kind,
    output logic [BYTE_W-1:0] out_byte,
    output logic [1:0]        error_code,
    output logic              last
);

    crcfr_cmd_t    cmd;
    crcfr_status_t status;

    crcfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    crcfr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_kind   (out_kind),
        .out_byte   (out_byte),
        .error_code (error_code),
        .last       (last),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

/* rtl/crcfr_ctrl.sv */
// Controller: sequences word accept, bit-serial CRC, and result emission.
module crcfr_ctrl
    import crcfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  crcfr_status_t status,
    output crcfr_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_ERR,
        S_READ,
        S_LOAD
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.ev_crc)
                    begin
                        state_next = S_CRC;
                        cnt_next   = 3'd7;
                    end
                    else if (status.ev_err)
                    begin
                        state_next = S_ERR;
                    end
                    else if (status.ev_good)
                    begin
                        cmd.clear_k = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            S_CRC:
            begin
                cmd.crc_shift = 1'b1;
                if (cnt_reg == 3'd0)
                    state_next = S_IDLE;
                else
                    cnt_next = cnt_reg - 3'd1;
            end
            S_ERR:
            begin
                if (status.can_load)
                begin
                    cmd.load_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (status.can_load)
                begin
                    cmd.load_item = 1'b1;
                    if (status.k_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.inc_k  = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/crcfr_dp.sv */
// Datapath: frame parsing registers, payload memory, CRC register and output register.
module crcfr_dp
    import crcfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [BYTE_W-1:0]  cfg_data,
    input  logic [BYTE_W-1:0]  rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         out_kind,
    output logic [BYTE_W-1:0]  out_byte,
    output logic [1:0]         error_code,
    output logic               last,
    input  crcfr_cmd_t         cmd,
    output crcfr_status_t      status
);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_LENGTH,
        PH_BODY
    } phase_t;

    logic [BYTE_W-1:0] hdr_first_reg, hdr_second_reg;
    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [CRC_W-1:0]  rcrc_reg, rcrc_next;
    logic [1:0]        err_reg, err_next;
    logic [POS_W-1:0]  k_reg;
    logic              mem_we;
    logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              out_valid_reg;
    logic [1:0]        out_kind_reg, out_err_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic [8:0]        pos_w, len_w, k_w;
    logic              ev_crc, ev_err, ev_good;

    assign pos_w = 9'(pos_reg);
    assign len_w = 9'(len_reg);
    assign k_w   = 9'(k_reg);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        rcrc_next  = rcrc_reg;
        err_next   = err_reg;
        mem_we     = 1'b0;
        ev_crc     = 1'b0;
        ev_err     = 1'b0;
        ev_good    = 1'b0;
        case (phase_reg)
            PH_FIRST:
            begin
                if (rx_byte == hdr_first_reg)
                    phase_next = PH_SECOND;
            end
            PH_SECOND:
            begin
                pos_next   = '0;
                phase_next = (rx_byte == hdr_second_reg) ? PH_LENGTH : PH_FIRST;
            end
            PH_LENGTH:
            begin
                pos_next = '0;
                if (rx_byte == '0 || rx_byte > BYTE_W'(MAX_PAYLOAD))
                begin
                    ev_err     = 1'b1;
                    err_next   = ERR_LENGTH;
                    phase_next = PH_FIRST;
                end
                else
                begin
                    len_next   = rx_byte;
                    crc_next   = CRC_INIT;
                    rcrc_next  = '0;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_w < len_w)
                begin
                    mem_we   = 1'b1;
                    ev_crc   = 1'b1;
                    crc_next = crc_reg ^ {rx_byte, 8'h00};
                end
                else if (pos_w == len_w)
                begin
                    rcrc_next = {8'h00, rx_byte};
                end
                else if (pos_w == len_w + 9'd1)
                begin
                    rcrc_next = {rx_byte, rcrc_reg[7:0]};
                end
                else if (pos_w == len_w + 9'd2)
                begin
                    if (rx_byte != hdr_first_reg)
                    begin
                        ev_err     = 1'b1;
                        err_next   = ERR_TRAILER;
                        phase_next = PH_FIRST;
                        pos_next   = '0;
                    end
                end
                else
                begin
                    phase_next = PH_FIRST;
                    pos_next   = '0;
                    if (pos_w == len_w + 9'd3)
                    begin
                        if (rx_byte != hdr_second_reg)
                        begin
                            ev_err   = 1'b1;
                            err_next = ERR_TRAILER;
                        end
                        else if (crc_reg != rcrc_reg)
                        begin
                            ev_err   = 1'b1;
                            err_next = ERR_CRC;
                        end
                        else
                        begin
                            ev_good = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_FIRST;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= HEADER_FIRST_RST;
            hdr_second_reg <= HEADER_SECOND_RST;
            phase_reg      <= PH_FIRST;
            pos_reg        <= '0;
            len_reg        <= '0;
            crc_reg        <= CRC_INIT;
            rcrc_reg       <= '0;
            err_reg        <= ERR_NONE;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_HEADER_FIRST)
                    hdr_first_reg <= cfg_data;
                else
                    hdr_second_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                len_reg   <= len_next;
                crc_reg   <= crc_next;
                rcrc_reg  <= rcrc_next;
                err_reg   <= err_next;
            end
            else if (cmd.crc_shift)
            begin
                crc_reg <= crc_reg[CRC_W-1] ? ({crc_reg[CRC_W-2:0], 1'b0} ^ CRC_POLY)
                                            : {crc_reg[CRC_W-2:0], 1'b0};
            end
            if (cmd.clear_k)
                k_reg <= '0;
            else if (cmd.inc_k)
                k_reg <= k_reg + 1'b1;
            if (cmd.load_err || cmd.load_item)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // k < len: payload; len+2: p0; otherwise p1
    always_comb
    begin
        if (k_w < len_w)
            rd_addr = k_reg[ADDR_W-1:0];
        else if (k_w == len_w + 9'd2)
            rd_addr = '0;
        else
            rd_addr = ADDR_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && mem_we)
            mem[pos_reg[ADDR_W-1:0]] <= rx_byte;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_err)
        begin
            out_kind_reg <= KIND_ERROR;
            out_byte_reg <= '0;
            out_err_reg  <= err_reg;
            out_last_reg <= 1'b1;
        end
        else if (cmd.load_item)
        begin
            out_err_reg  <= ERR_NONE;
            out_last_reg <= status.k_last;
            if (k_w < len_w)
            begin
                out_kind_reg <= KIND_PAYLOAD;
                out_byte_reg <= rd_data_reg;
            end
            else
            begin
                out_kind_reg <= KIND_ACK;
                if (k_w == len_w || k_w == len_w + 9'd4)
                    out_byte_reg <= hdr_first_reg;
                else if (k_w == len_w + 9'd1 || k_w == len_w + 9'd5)
                    out_byte_reg <= hdr_second_reg;
                else if (k_w == len_w + 9'd2)
                    out_byte_reg <= rd_data_reg;
                else
                    out_byte_reg <= (len_reg >= 8'd2) ? rd_data_reg : '0;
            end
        end
    end

    assign status.ev_crc   = ev_crc;
    assign status.ev_err   = ev_err;
    assign status.ev_good  = ev_good;
    assign status.k_last   = (k_w == len_w + 9'd5);
    assign status.can_load = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_byte   = out_byte_reg;
    assign error_code = out_err_reg;
    assign last       = out_last_reg;

endmodule
